/* design/prcp_pkg.sv */
// prcp_pkg: shared types and constants of the payload request command parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package prcp_pkg;

    // command kinds, as carried in the kind field of the input word
    localparam logic [1:0] KIND_S1_SIZE  = 2'd0;
    localparam logic [1:0] KIND_S2_SIZE  = 2'd1;
    localparam logic [1:0] KIND_S2_IMAGE = 2'd2;
    localparam logic [1:0] KIND_S3_READ  = 2'd3;

    // response sources
    localparam logic [1:0] SRC_S1_SIZE  = 2'd0;
    localparam logic [1:0] SRC_S2_SIZE  = 2'd1;
    localparam logic [1:0] SRC_S2_IMAGE = 2'd2;
    localparam logic [1:0] SRC_S3_IMAGE = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_S1_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_S2_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_S2_IMAGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHK_S3_READ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_S2_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_S3_LENGTH    = 3'd5;

    // byte positions within a command
    localparam logic [4:0] IDX_CHECK    = 5'd3;
    localparam logic [4:0] IDX_CRC_FLAG = 5'd20;
    localparam logic [4:0] IDX_FLAG_CHK = 5'd21;

    // groups of four byte positions (byte_index[4:2])
    localparam logic [2:0] GRP_HEAD       = 3'd0;
    localparam logic [2:0] GRP_OFFSET     = 3'd1;
    localparam logic [2:0] GRP_OFFSET_CHK = 3'd2;
    localparam logic [2:0] GRP_SIZE       = 3'd3;
    localparam logic [2:0] GRP_SIZE_CHK   = 3'd4;
    localparam logic [2:0] GRP_TAIL       = 3'd5;

    localparam logic [31:0] SIZE_WORD_LEN = 32'd4;
    localparam logic [31:0] ALL_ONES_32   = 32'hFFFF_FFFF;
    localparam logic [7:0]  ALL_ONES_8    = 8'hFF;

    typedef struct packed {
        logic       start_req;
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [1:0]  source;
        logic [31:0] offset;
        logic [31:0] length;
        logic        crc_follows;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  check_stage1_size;
        logic [7:0]  check_stage2_size;
        logic [7:0]  check_stage2_image;
        logic [7:0]  check_stage3_read;
        logic [31:0] stage2_length;
        logic [31:0] stage3_length;
    } t_cfg;

endpackage

`default_nettype wire

/* design/payload_request_command_parser_unit.sv */
// payload_request_command_parser_unit: top level of the command byte parser.
// Depends on prcp_pkg, prcp_cfg_regs, prcp_byte_parse, prcp_out_reg.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_data  (start_req,kind,byte)
//   out     | output    | o_out_valid/ i_out_stall| o_out_data (status,src,off,len,crc)
//   cfg     | input     | i_cfg_wr_en             | i_cfg_index, i_cfg_wr_data
//
// One byte a cycle, unless a response waits for the result register: input register,
// one pass of compare/byte-insert logic, result register.
// Reset (synchronous, low) clears config registers, parser state and both valid flags.
// A byte that gives no response moves on even while the output is stalled; one that
// gives a response waits in the input register until the result register is free.
`default_nettype none

module payload_request_command_parser_unit
    import prcp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  t_in_word                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_data,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_wr_data
);

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_word r_in_data;
    logic     fire;
    logic     emit;
    logic     out_free;
    t_out_word result;
    logic     in_accept;

    prcp_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_index   (i_cfg_index),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (cfg)
    );

    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    prcp_byte_parse u_byte_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (r_in_valid),
        .i_word       (r_in_data),
        .i_cfg        (cfg),
        .i_out_free   (out_free),
        .o_fire       (fire),
        .o_emit       (emit),
        .o_result     (result)
    );

    prcp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_data  (result),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // stall is only raised against a held word
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall without a held word");

    // a held, stalled word is not dropped
    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=> r_in_valid)
        else $error("stalled input word lost");

    // an error response carries no region
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STATUS_ERR) |->
        (o_out_data.source == SRC_S1_SIZE && o_out_data.offset == 32'd0
         && o_out_data.length == 32'd0 && !o_out_data.crc_follows))
        else $error("error response with non-zero fields");

    // a new response never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!o_out_valid || !i_out_stall))
        else $error("response overwritten in result register");

endmodule

`default_nettype wire

/* design/prcp_cfg_regs.sv */
// prcp_cfg_regs: configuration registers written through the plain write port.
// Depends on prcp_pkg.
`default_nettype none

module prcp_cfg_regs
    import prcp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [31:0]          i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (i_index)
                REG_CHK_S1_SIZE:  r_cfg.check_stage1_size  <= i_wr_data[7:0];
                REG_CHK_S2_SIZE:  r_cfg.check_stage2_size  <= i_wr_data[7:0];
                REG_CHK_S2_IMAGE: r_cfg.check_stage2_image <= i_wr_data[7:0];
                REG_CHK_S3_READ:  r_cfg.check_stage3_read  <= i_wr_data[7:0];
                REG_S2_LENGTH:    r_cfg.stage2_length      <= i_wr_data;
                REG_S3_LENGTH:    r_cfg.stage3_length      <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/prcp_byte_parse.sv */
// prcp_byte_parse: command state and per-byte decision logic.
// Takes the registered input word, updates the parser state, forms the response.
// Depends on prcp_pkg.
`default_nettype none

module prcp_byte_parse
    import prcp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_word_valid,
    input  t_in_word      i_word,
    input  t_cfg          i_cfg,
    input  wire logic     i_out_free,
    output logic          o_fire,
    output logic          o_emit,
    output t_out_word     o_result
);

    logic        r_busy, n_busy;
    logic [1:0]  r_cmd, n_cmd;
    logic [4:0]  r_idx, n_idx;
    logic [31:0] r_off, n_off;
    logic [31:0] r_off_chk, n_off_chk;
    logic [31:0] r_size, n_size;
    logic [31:0] r_size_chk, n_size_chk;
    logic        r_crc, n_crc;

    logic        active;
    logic        emit;
    logic [7:0]  chk;
    logic        ok_off, ok_size, ok_crc;
    t_out_word   res;

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] v;
        v = w;
        v[pos*8 +: 8] = b;
        return v;
    endfunction

    always_comb begin
        case (n_cmd)
            KIND_S1_SIZE: chk = i_cfg.check_stage1_size;
            KIND_S2_SIZE: chk = i_cfg.check_stage2_size;
            default:      chk = i_cfg.check_stage2_image;
        endcase
    end

    assign ok_off  = ((r_off ^ r_off_chk) == ALL_ONES_32) && (r_off < i_cfg.stage3_length);
    assign ok_size = (r_size ^ r_size_chk) == ALL_ONES_32;
    assign ok_crc  = ({7'd0, r_crc} ^ i_word.data_byte) == ALL_ONES_8;

    always_comb begin
        n_busy     = r_busy;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_off      = r_off;
        n_off_chk  = r_off_chk;
        n_size     = r_size;
        n_size_chk = r_size_chk;
        n_crc      = r_crc;
        active     = 1'b1;
        emit       = 1'b0;
        res        = '0;

        if (i_word.start_req) begin
            n_busy = 1'b1;
            n_cmd  = i_word.kind;
            n_idx  = IDX_CHECK;
        end else if (r_busy) begin
            n_idx = r_idx + 5'd1;
        end else begin
            active = 1'b0;              // stray byte while idle
        end

        if (active) begin
            if (n_cmd != KIND_S3_READ) begin
                n_busy = 1'b0;
                if (n_idx == IDX_CHECK && i_word.data_byte == chk) begin
                    emit            = 1'b1;
                    res.status      = STATUS_OK;
                    res.source      = n_cmd;
                    res.length      = (n_cmd == KIND_S2_IMAGE) ? i_cfg.stage2_length
                                                               : SIZE_WORD_LEN;
                    res.crc_follows = (n_cmd == KIND_S2_IMAGE);
                end
            end else begin
                case (n_idx[4:2])
                    GRP_HEAD: begin
                        if (n_idx != IDX_CHECK
                            || i_word.data_byte != i_cfg.check_stage3_read) begin
                            n_busy = 1'b0;
                        end
                    end
                    GRP_OFFSET:     n_off      = put_byte(r_off, n_idx[1:0], i_word.data_byte);
                    GRP_OFFSET_CHK: n_off_chk  = put_byte(r_off_chk, n_idx[1:0],
                                                          i_word.data_byte);
                    GRP_SIZE:       n_size     = put_byte(r_size, n_idx[1:0], i_word.data_byte);
                    GRP_SIZE_CHK:   n_size_chk = put_byte(r_size_chk, n_idx[1:0],
                                                          i_word.data_byte);
                    GRP_TAIL: begin
                        if (n_idx == IDX_CRC_FLAG) begin
                            n_crc = (i_word.data_byte != 8'd0);
                        end else if (n_idx == IDX_FLAG_CHK) begin
                            n_busy = 1'b0;
                            emit   = 1'b1;
                            if (ok_off && ok_size && ok_crc) begin
                                res.status      = STATUS_OK;
                                res.source      = SRC_S3_IMAGE;
                                res.offset      = r_off;
                                res.length      = r_size;
                                res.crc_follows = r_crc;
                            end else begin
                                res.status = STATUS_ERR;
                            end
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                    default: n_busy = 1'b0;
                endcase
            end
        end
    end

    // a word that yields no response never waits on the output side
    assign o_fire   = i_word_valid && (!emit || i_out_free);
    assign o_emit   = o_fire && emit;
    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cmd      <= KIND_S1_SIZE;
            r_idx      <= '0;
            r_off      <= '0;
            r_off_chk  <= '0;
            r_size     <= '0;
            r_size_chk <= '0;
            r_crc      <= 1'b0;
        end else if (o_fire) begin
            r_busy     <= n_busy;
            r_cmd      <= n_cmd;
            r_idx      <= n_idx;
            r_off      <= n_off;
            r_off_chk  <= n_off_chk;
            r_size     <= n_size;
            r_size_chk <= n_size_chk;
            r_crc      <= n_crc;
        end
    end

endmodule

`default_nettype wire

/* design/prcp_out_reg.sv */
// prcp_out_reg: result register holding one response word until it is taken.
// Depends on prcp_pkg.
`default_nettype none

module prcp_out_reg
    import prcp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  t_out_word i_data,
    input  wire logic i_stall,
    output logic      o_free,
    output logic      o_valid,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
